// ===== hw/rtl/lfupr_pkg.sv =====
// Shared constants and types for the LFU page replacement block.
package lfupr_pkg;

	localparam int NUM_FRAMES = 4;
	localparam int PAGE_BITS  = 8;
	localparam int COUNT_BITS = 16;
	localparam int RANK_BITS  = 4;
	localparam int TOTAL_BITS = 16;

	localparam int FRAME_W    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int FILL_W     = $clog2(NUM_FRAMES + 1);
	localparam int TABLE_SIZE = 1 << PAGE_BITS;

	typedef logic [PAGE_BITS-1:0]  page_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [FRAME_W-1:0]    frame_idx_t;
	typedef logic [RANK_BITS-1:0]  rank_t;
	typedef logic [TOTAL_BITS-1:0] total_t;

	localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam total_t TOTAL_MAX = {TOTAL_BITS{1'b1}};

	typedef struct packed {
		logic       hit;
		frame_idx_t slot;
		logic       ev_valid;
		page_t      ev_page;
		total_t     fault_total;
		total_t     ref_total;
	} result_t;

endpackage

// ===== hw/rtl/lfupr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lfupr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/lfupr_count_table.sv =====
// Per-page reference counter table: RAM plus per-entry valid bits cleared at reset.
module lfupr_count_table (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    rd_en,
	input  lfupr_pkg::page_t        rd_addr,
	input  logic                    wr_en,
	input  lfupr_pkg::page_t        wr_addr,
	input  lfupr_pkg::count_t       wr_data,
	output lfupr_pkg::count_t       rd_count
);

	logic [lfupr_pkg::TABLE_SIZE-1:0] entry_vld_q;
	logic                             rd_vld_q;
	lfupr_pkg::count_t                rdata;

	lfupr_ram #(
		.WIDTH(lfupr_pkg::COUNT_BITS),
		.DEPTH(lfupr_pkg::TABLE_SIZE)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= '0;
			rd_vld_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				entry_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= entry_vld_q[rd_addr];
			end
		end
	end

	assign rd_count = rd_vld_q ? rdata : '0;

endmodule

// ===== hw/rtl/lfupr_frames.sv =====
// Frame state, hit lookup, LFU victim choice with LRU tie-break, and fault counting.
module lfupr_frames (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  lfupr_pkg::page_t     page,
	input  lfupr_pkg::count_t    table_count,
	output lfupr_pkg::result_t   result,
	output lfupr_pkg::count_t    new_count
);

	logic [lfupr_pkg::NUM_FRAMES-1:0] valid_q;
	lfupr_pkg::page_t                 page_q [lfupr_pkg::NUM_FRAMES];
	lfupr_pkg::count_t                cnt_q  [lfupr_pkg::NUM_FRAMES];
	lfupr_pkg::rank_t                 rank_q [lfupr_pkg::NUM_FRAMES];
	lfupr_pkg::rank_t                 rank_next [lfupr_pkg::NUM_FRAMES];
	logic [lfupr_pkg::FILL_W-1:0]     fill_q;
	lfupr_pkg::total_t                fault_q;
	lfupr_pkg::total_t                fault_next;

	logic                  hit;
	logic                  full;
	logic                  was_valid;
	lfupr_pkg::frame_idx_t hit_idx;
	lfupr_pkg::frame_idx_t best_idx;
	lfupr_pkg::count_t     best_cnt;
	lfupr_pkg::rank_t      best_rank;
	lfupr_pkg::frame_idx_t slot;
	lfupr_pkg::rank_t      old_rank;
	lfupr_pkg::count_t     base_count;
	logic [lfupr_pkg::COUNT_BITS+lfupr_pkg::TOTAL_BITS-1:0] wide_count;

	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int k = 0; k < lfupr_pkg::NUM_FRAMES; k++) begin
			if (!hit && valid_q[k] && page_q[k] == page) begin
				hit     = 1'b1;
				hit_idx = lfupr_pkg::FRAME_W'(k);
			end
		end

		full = (fill_q == lfupr_pkg::FILL_W'(lfupr_pkg::NUM_FRAMES));

		best_idx  = '0;
		best_cnt  = cnt_q[0];
		best_rank = rank_q[0];
		for (int k = 1; k < lfupr_pkg::NUM_FRAMES; k++) begin
			if (cnt_q[k] < best_cnt || (cnt_q[k] == best_cnt && rank_q[k] > best_rank)) begin
				best_idx  = lfupr_pkg::FRAME_W'(k);
				best_cnt  = cnt_q[k];
				best_rank = rank_q[k];
			end
		end

		if (hit) begin
			slot = hit_idx;
		end else if (full) begin
			slot = best_idx;
		end else begin
			slot = fill_q[lfupr_pkg::FRAME_W-1:0];
		end
		was_valid = hit || full;
		old_rank  = rank_q[slot];

		for (int k = 0; k < lfupr_pkg::NUM_FRAMES; k++) begin
			rank_next[k] = rank_q[k];
			if (lfupr_pkg::FRAME_W'(k) == slot) begin
				rank_next[k] = '0;
			end else if (valid_q[k] && (!was_valid || rank_q[k] < old_rank)) begin
				rank_next[k] = rank_q[k] + 1'b1;
			end
		end

		base_count = hit ? cnt_q[hit_idx] : table_count;
		new_count  = (base_count == lfupr_pkg::COUNT_MAX) ? base_count : base_count + 1'b1;
		wide_count = {{lfupr_pkg::TOTAL_BITS{1'b0}}, new_count};

		fault_next = (!hit && fault_q != lfupr_pkg::TOTAL_MAX) ? fault_q + 1'b1 : fault_q;

		result.hit         = hit;
		result.slot        = slot;
		result.ev_valid    = !hit && full;
		result.ev_page     = (!hit && full) ? page_q[best_idx] : '0;
		result.fault_total = fault_next;
		result.ref_total   = (wide_count > {{lfupr_pkg::COUNT_BITS{1'b0}}, lfupr_pkg::TOTAL_MAX})
			? lfupr_pkg::TOTAL_MAX : wide_count[lfupr_pkg::TOTAL_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fill_q  <= '0;
			fault_q <= '0;
			for (int k = 0; k < lfupr_pkg::NUM_FRAMES; k++) begin
				rank_q[k] <= '0;
			end
		end else if (fire) begin
			valid_q[slot] <= 1'b1;
			fault_q       <= fault_next;
			if (!was_valid) begin
				fill_q <= fill_q + 1'b1;
			end
			for (int k = 0; k < lfupr_pkg::NUM_FRAMES; k++) begin
				rank_q[k] <= rank_next[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			page_q[slot] <= page;
			cnt_q[slot]  <= new_count;
		end
	end

endmodule

// ===== hw/rtl/lfu_page_replacement_top.sv =====
// Top level of the LFU page replacement block with LRU tie-break.
// Takes one page request per cycle unless a stalled result side holds it, and returns one result
// per request from the result register. The first stage reads the page's counter from
// the two-port count table, which takes the previous request's counter write in the same
// cycle; the second stage does the frame lookup, victim choice and counter update in one pass
// and loads the result register. Counts of resident pages live in the frame
// registers, so a request that follows one to the same page needs no table forwarding. The table
// is ready right after reset: per-entry valid bits replace a clearing pass.
module lfu_page_replacement_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [7:0]  page_number,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        hit,
	output logic [3:0]  frame_slot,
	output logic        evicted_valid,
	output logic [7:0]  evicted_page,
	output logic [15:0] fault_total,
	output logic [15:0] reference_total
);

	logic               vld_s1;
	lfupr_pkg::page_t   page_s1;
	logic               vld_s2;
	lfupr_pkg::result_t res_s2;
	logic               fire_s1;
	logic               accept;
	lfupr_pkg::page_t   req_page;
	lfupr_pkg::count_t  table_count;
	lfupr_pkg::count_t  new_count;
	lfupr_pkg::result_t result;

	assign req_page  = lfupr_pkg::PAGE_BITS'(page_number);
	assign fire_s1   = vld_s1 && (!vld_s2 || res_ready);
	assign req_ready = !vld_s1 || fire_s1;
	assign accept    = req_valid && req_ready;

	lfupr_count_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (req_page),
		.wr_en    (fire_s1),
		.wr_addr  (page_s1),
		.wr_data  (new_count),
		.rd_count (table_count)
	);

	lfupr_frames u_frames (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire_s1),
		.page        (page_s1),
		.table_count (table_count),
		.result      (result),
		.new_count   (new_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (req_ready) begin
				vld_s1 <= req_valid;
			end
			if (fire_s1) begin
				vld_s2 <= 1'b1;
			end else if (res_ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_s1 <= req_page;
		end
		if (fire_s1) begin
			res_s2 <= result;
		end
	end

	assign res_valid       = vld_s2;
	assign hit             = res_s2.hit;
	assign frame_slot      = 4'(res_s2.slot);
	assign evicted_valid   = res_s2.ev_valid;
	assign evicted_page    = 8'(res_s2.ev_page);
	assign fault_total     = res_s2.fault_total;
	assign reference_total = res_s2.ref_total;

endmodule

// ===== hw/rtl/lfupr_checker.sv =====
// Port-level checks for the LFU page replacement top level, bound to it.
module lfupr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        hit,
	input logic [3:0]  frame_slot,
	input logic        evicted_valid,
	input logic [7:0]  evicted_page,
	input logic [15:0] fault_total,
	input logic [15:0] reference_total
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(frame_slot) && $stable(hit)
			&& $stable(evicted_page) && $stable(fault_total) && $stable(reference_total))
		else $error("result changed while stalled");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (hit || !evicted_valid) |-> !evicted_valid && evicted_page == 8'd0)
		else $error("eviction reported without a full-frame miss");

	a_evict_after_fill: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && evicted_valid |-> !hit
			&& fault_total >= 16'(lfupr_pkg::NUM_FRAMES))
		else $error("eviction before all frames were filled");

	a_slot_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> reference_total != 16'd0
			&& frame_slot < 4'(lfupr_pkg::NUM_FRAMES))
		else $error("bad slot or zero reference count");

endmodule

bind lfu_page_replacement_top lfupr_checker u_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (res_valid),
	.res_ready       (res_ready),
	.hit             (hit),
	.frame_slot      (frame_slot),
	.evicted_valid   (evicted_valid),
	.evicted_page    (evicted_page),
	.fault_total     (fault_total),
	.reference_total (reference_total)
);
